// File: rtl/core/cql_pkg.sv
`timescale 1ns / 1ps

package cql_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } cql_in_t;

  typedef struct packed {
    logic       item_kind;
    logic [4:0] token_code;
    logic [7:0] text_byte;
    logic       last;
  } cql_out_t;

  // Per-byte results handed from the lexer step to the output queue.
  typedef struct packed {
    logic [1:0] cnt;
    cql_out_t   item0;
    cql_out_t   item1;
  } cql_res_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_WESC  = 3'd2,
    M_QUOTE = 3'd3,
    M_QESC  = 3'd4,
    M_GT    = 3'd5,
    M_LT    = 3'd6
  } cql_mode_t;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [4:0] TK_END   = 5'd0;
  localparam logic [4:0] TK_LPAR  = 5'd1;
  localparam logic [4:0] TK_RPAR  = 5'd2;
  localparam logic [4:0] TK_EQ    = 5'd3;
  localparam logic [4:0] TK_GT    = 5'd4;
  localparam logic [4:0] TK_LT    = 5'd5;
  localparam logic [4:0] TK_SLASH = 5'd6;
  localparam logic [4:0] TK_GE    = 5'd7;
  localparam logic [4:0] TK_LE    = 5'd8;
  localparam logic [4:0] TK_NE    = 5'd9;
  localparam logic [4:0] TK_AND   = 5'd10;
  localparam logic [4:0] TK_OR    = 5'd11;
  localparam logic [4:0] TK_NOT   = 5'd12;
  localparam logic [4:0] TK_EXACT = 5'd13;
  localparam logic [4:0] TK_ALL   = 5'd14;
  localparam logic [4:0] TK_PROX  = 5'd15;
  localparam logic [4:0] TK_ANY   = 5'd16;
  localparam logic [4:0] TK_SCR   = 5'd17;
  localparam logic [4:0] TK_TERM  = 5'd18;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_BSL   = 8'h5c;

  // Keyword prefixes, first byte in the low bits, unused bytes zero.
  localparam logic [39:0] KW_AND   = 40'h0000646e61;
  localparam logic [39:0] KW_OR    = 40'h000000726f;
  localparam logic [39:0] KW_NOT   = 40'h0000746f6e;
  localparam logic [39:0] KW_EXACT = 40'h7463617865;
  localparam logic [39:0] KW_ALL   = 40'h00006c6c61;
  localparam logic [31:0] KW_PROX  = 32'h786f7270;
  localparam logic [39:0] KW_ANY   = 40'h0000796e61;
  localparam logic [39:0] KW_SCR   = 40'h0000726373;

  function automatic logic word_delim(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_NL) || (b == CH_LPAR) || (b == CH_RPAR) ||
           (b == CH_EQ) || (b == CH_LT) || (b == CH_GT) || (b == CH_SLASH);
  endfunction

  function automatic logic [4:0] word_code(input logic [39:0] pfx, input logic [2:0] len);
    logic [4:0] code;
    code = TK_TERM;
    if (len == 3'd3 && pfx == KW_AND) code = TK_AND;
    else if (len == 3'd2 && pfx == KW_OR) code = TK_OR;
    else if (len == 3'd3 && pfx == KW_NOT) code = TK_NOT;
    else if (len == 3'd5 && pfx == KW_EXACT) code = TK_EXACT;
    else if (len == 3'd3 && pfx == KW_ALL) code = TK_ALL;
    else if (len >= 3'd4 && pfx[31:0] == KW_PROX) code = TK_PROX;
    else if (len == 3'd3 && pfx == KW_ANY) code = TK_ANY;
    else if (len == 3'd3 && pfx == KW_SCR) code = TK_SCR;
    return code;
  endfunction

  function automatic cql_out_t mk_item(input logic kind, input logic [4:0] code,
                                       input logic [7:0] b);
    cql_out_t it;
    it.item_kind  = kind;
    it.token_code = code;
    it.text_byte  = b;
    it.last       = 1'b0;
    return it;
  endfunction

endpackage

// File: rtl/core/cql_lex.sv
`timescale 1ns / 1ps

// Lexer state and the per-byte step. The state advances only when step_en is high.
module cql_lex (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  cql_pkg::cql_in_t  step_in,
  output cql_pkg::cql_res_t step_res
);

  cql_pkg::cql_mode_t mode_r, mode_nxt;
  logic [39:0] prefix_r, prefix_nxt;
  logic [2:0]  len_r, len_nxt;

  logic [7:0]       b;
  logic             eof;
  logic             pre_v, run_start, st_v;
  cql_pkg::cql_out_t pre_item, st_item;

  assign b   = step_in.data_byte;
  assign eof = step_in.end_of_input;

  always_comb begin
    mode_nxt   = mode_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    pre_v      = 1'b0;
    pre_item   = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_END, cql_pkg::CH_NUL);
    run_start  = 1'b0;
    st_v       = 1'b0;
    st_item    = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_END, cql_pkg::CH_NUL);

    case (mode_r)
      cql_pkg::M_WORD, cql_pkg::M_WESC: begin
        if (eof || (mode_r == cql_pkg::M_WORD && (b == cql_pkg::CH_NUL ||
                                                  cql_pkg::word_delim(b)))) begin
          pre_v      = 1'b1;
          pre_item   = cql_pkg::mk_item(cql_pkg::KIND_DONE,
                                        cql_pkg::word_code(prefix_r, len_r),
                                        cql_pkg::CH_NUL);
          mode_nxt   = cql_pkg::M_IDLE;
          prefix_nxt = '0;
          len_nxt    = '0;
          // A zero byte ends the word and is consumed.
          run_start  = eof || (b != cql_pkg::CH_NUL);
        end else if (mode_r == cql_pkg::M_WORD && b == cql_pkg::CH_BSL) begin
          mode_nxt = cql_pkg::M_WESC;
        end else begin
          mode_nxt = cql_pkg::M_WORD;
          if (b != cql_pkg::CH_NUL) begin
            pre_v    = 1'b1;
            pre_item = cql_pkg::mk_item(cql_pkg::KIND_TEXT, cql_pkg::TK_TERM, b);
            if (len_r < 3'd5) prefix_nxt[len_r*8 +: 8] = b;
            if (len_r < 3'd6) len_nxt = len_r + 3'd1;
          end
        end
      end
      cql_pkg::M_QUOTE, cql_pkg::M_QESC: begin
        if (eof || (mode_r == cql_pkg::M_QUOTE && b == cql_pkg::CH_QUOTE)) begin
          pre_v    = 1'b1;
          pre_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_TERM, cql_pkg::CH_NUL);
          mode_nxt = cql_pkg::M_IDLE;
        end else if (mode_r == cql_pkg::M_QUOTE && b == cql_pkg::CH_BSL) begin
          mode_nxt = cql_pkg::M_QESC;
        end else begin
          mode_nxt = cql_pkg::M_QUOTE;
          if (b != cql_pkg::CH_NUL) begin
            pre_v    = 1'b1;
            pre_item = cql_pkg::mk_item(cql_pkg::KIND_TEXT, cql_pkg::TK_TERM, b);
          end
        end
      end
      cql_pkg::M_GT: begin
        pre_v = 1'b1;
        if (!eof && b == cql_pkg::CH_EQ) begin
          pre_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_GE, cql_pkg::CH_NUL);
          mode_nxt = cql_pkg::M_IDLE;
        end else begin
          pre_item  = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_GT, cql_pkg::CH_NUL);
          run_start = 1'b1;
        end
      end
      cql_pkg::M_LT: begin
        pre_v = 1'b1;
        if (!eof && b == cql_pkg::CH_EQ) begin
          pre_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_LE, cql_pkg::CH_NUL);
          mode_nxt = cql_pkg::M_IDLE;
        end else if (!eof && b == cql_pkg::CH_GT) begin
          pre_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_NE, cql_pkg::CH_NUL);
          mode_nxt = cql_pkg::M_IDLE;
        end else begin
          pre_item  = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_LT, cql_pkg::CH_NUL);
          run_start = 1'b1;
        end
      end
      default: begin
        run_start = 1'b1;
      end
    endcase

    // Token-start handling, shared by idle and by bytes that are processed again.
    if (run_start) begin
      mode_nxt = cql_pkg::M_IDLE;
      if (eof || b == cql_pkg::CH_NUL || b == cql_pkg::CH_NL) begin
        st_v = 1'b1;
      end else if (b inside {cql_pkg::CH_SP, [cql_pkg::CH_TAB:cql_pkg::CH_CR]}) begin
        st_v = 1'b0;
      end else if (b == cql_pkg::CH_GT) begin
        mode_nxt = cql_pkg::M_GT;
      end else if (b == cql_pkg::CH_LT) begin
        mode_nxt = cql_pkg::M_LT;
      end else if (b == cql_pkg::CH_LPAR) begin
        st_v    = 1'b1;
        st_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_LPAR, cql_pkg::CH_NUL);
      end else if (b == cql_pkg::CH_RPAR) begin
        st_v    = 1'b1;
        st_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_RPAR, cql_pkg::CH_NUL);
      end else if (b == cql_pkg::CH_EQ) begin
        st_v    = 1'b1;
        st_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_EQ, cql_pkg::CH_NUL);
      end else if (b == cql_pkg::CH_SLASH) begin
        st_v    = 1'b1;
        st_item = cql_pkg::mk_item(cql_pkg::KIND_DONE, cql_pkg::TK_SLASH, cql_pkg::CH_NUL);
      end else if (b == cql_pkg::CH_QUOTE) begin
        mode_nxt = cql_pkg::M_QUOTE;
      end else begin
        // First byte of a word is stored literally, backslash included.
        st_v       = 1'b1;
        st_item    = cql_pkg::mk_item(cql_pkg::KIND_TEXT, cql_pkg::TK_TERM, b);
        mode_nxt   = cql_pkg::M_WORD;
        prefix_nxt = {32'd0, b};
        len_nxt    = 3'd1;
      end
    end
  end

  always_comb begin
    step_res       = '0;
    step_res.cnt   = {1'b0, pre_v} + {1'b0, st_v};
    if (pre_v) begin
      step_res.item0 = pre_item;
      step_res.item1 = st_item;
    end else begin
      step_res.item0 = st_item;
    end
    step_res.item0.last = (step_res.cnt == 2'd1);
    step_res.item1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cql_pkg::M_IDLE;
      prefix_r <= '0;
      len_r    <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

// File: rtl/core/cql_outq.sv
`timescale 1ns / 1ps

// Result queue: takes up to two results per cycle, delivers one per transaction.
module cql_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cql_pkg::cql_res_t            push_res,
  output logic [cql_pkg::QCntW-1:0]    room,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cql_pkg::cql_out_t            out_data
);

  cql_pkg::cql_out_t q_r [cql_pkg::QDepth];
  logic [cql_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [cql_pkg::QCntW-1:0] cnt_r, push_n;
  logic pop;

  assign room      = cql_pkg::QCntW'(cql_pkg::QDepth) - cnt_r;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = push ? cql_pkg::QCntW'(push_res.cnt) : '0;
  assign wr_ptr1   = wr_ptr_r + cql_pkg::QPtrW'(1);

  always_ff @(posedge clk) begin
    if (push && push_res.cnt != 2'd0) q_r[wr_ptr_r] <= push_res.item0;
    if (push && push_res.cnt == 2'd2) q_r[wr_ptr1] <= push_res.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[cql_pkg::QPtrW-1:0];
      if (pop) rd_ptr_r <= rd_ptr_r + cql_pkg::QPtrW'(1);
      cnt_r <= cnt_r + push_n - (pop ? cql_pkg::QCntW'(1) : '0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_n <= room)
    else $error("result queue written beyond its free space");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cql_pkg::QCntW'(cql_pkg::QDepth))
    else $error("result queue count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == '0) |=> cnt_r == $past(cnt_r) - cql_pkg::QCntW'(1))
    else $error("result queue count did not drop after a lone read");

endmodule

// File: rtl/core/cql_query_lexer.sv
`timescale 1ns / 1ps
// A byte accepted into the input register is lexed once the result queue has room
// for all of its results; those results are written into the queue, and the first
// is then offered on the output from the queue's registered state.
// Throughput: one byte per cycle while results are taken as fast as they appear;
// a byte that yields two results needs two output transactions.
// Reset (rst_n low, synchronous) empties the input register and result queue and
// returns the lexer to idle between tokens with an empty word buffer.

// The block has three parts. An input register holds the byte of the most recent
// input transaction. The lexer step reads that byte together with the current mode,
// word prefix and word length, and in one pass of combinational logic works out the
// zero, one or two result items that the byte causes and the next lexer state. Those
// results land in a four-entry result queue that drives the output channel.
//
// A byte in the input register is consumed as soon as the queue has room for all of
// its results. Because stall only looks at registered state, the input side keeps
// flowing while earlier results are still waiting to be taken downstream.
module cql_query_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cql_pkg::cql_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cql_pkg::cql_out_t  out_data
);

  logic                      in_valid_r, in_valid_nxt;
  cql_pkg::cql_in_t          in_data_r;
  logic                      proc;
  logic                      in_take;
  cql_pkg::cql_res_t         step_res;
  logic [cql_pkg::QCntW-1:0] room;

  // The held byte is processed when every result it causes fits in the queue.
  assign proc     = in_valid_r && (cql_pkg::QCntW'(step_res.cnt) <= room);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (proc) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Payload register needs no reset; it is only looked at while in_valid_r is set.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  cql_lex u_lex (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (proc),
    .step_in  (in_data_r),
    .step_res (step_res)
  );

  cql_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (proc),
    .push_res  (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
